// File: rtl/core/ccff_pkg.sv
// ----------------------------------------------------------------------------
// ccff_pkg
// Shared types, operation codes and point selection for the cut-cell face
// wetted-fraction block.
// ----------------------------------------------------------------------------
package ccff_pkg;

    typedef struct packed {
        logic        [15:0] face_flags;
        logic signed [31:0] u_low;
        logic signed [31:0] u_high;
        logic signed [31:0] v_low;
        logic signed [31:0] v_high;
        logic signed [31:0] cut_u_at_vlow;
        logic signed [31:0] cut_v_at_uhigh;
        logic signed [31:0] cut_u_at_vhigh;
        logic signed [31:0] cut_v_at_ulow;
        logic        [30:0] extent_u;
        logic        [30:0] extent_v;
    } t_req;

    typedef struct packed {
        logic [16:0] wet_fraction;
        logic        geometry_error;
    } t_res;

    typedef struct packed {
        logic signed [31:0] u;
        logic signed [31:0] v;
    } t_point;

    localparam logic [3:0] OP_NOP     = 4'd0;
    localparam logic [3:0] OP_CLR     = 4'd1;
    localparam logic [3:0] OP_LD_P0   = 4'd2;
    localparam logic [3:0] OP_LD_PREV = 4'd3;
    localparam logic [3:0] OP_MUL_A   = 4'd4;
    localparam logic [3:0] OP_MUL_B   = 4'd5;
    localparam logic [3:0] OP_CROSS   = 4'd6;
    localparam logic [3:0] OP_ACC     = 4'd7;
    localparam logic [3:0] OP_MUL_D   = 4'd8;
    localparam logic [3:0] OP_DIV     = 4'd9;

    typedef struct packed {
        logic [3:0] op;
    } t_ctrl;

    typedef struct packed {
        logic den_zero;
        logic acc_gt;
        logic acc_eq;
    } t_stat;

    localparam logic [2:0] WET_ALL    = 3'd4;
    localparam logic [2:0] WET_NONE   = 3'd0;
    localparam logic [3:0] LSUM_FULL  = 4'd8;
    localparam logic [3:0] LSUM_THREE = 4'd6;
    localparam logic [3:0] LSUM_HALF  = 4'd5;

    function automatic t_point cand_point(t_req r, logic [2:0] k);
        t_point p;
        case (k)
            3'd0:    begin p.u = r.u_low;         p.v = r.v_low;          end
            3'd1:    begin p.u = r.cut_u_at_vlow; p.v = r.v_low;          end
            3'd2:    begin p.u = r.u_high;        p.v = r.v_low;          end
            3'd3:    begin p.u = r.u_high;        p.v = r.cut_v_at_uhigh; end
            3'd4:    begin p.u = r.u_high;        p.v = r.v_high;         end
            3'd5:    begin p.u = r.cut_u_at_vhigh; p.v = r.v_high;        end
            3'd6:    begin p.u = r.u_low;         p.v = r.v_high;         end
            default: begin p.u = r.u_low;         p.v = r.cut_v_at_ulow;  end
        endcase
        return p;
    endfunction

    function automatic logic cand_take(logic [15:0] f, logic [2:0] k);
        logic t;
        case (k)
            3'd0:    t = |f[5:4];
            3'd1:    t = f[12];
            3'd2:    t = |f[7:6];
            3'd3:    t = f[13];
            3'd4:    t = |f[9:8];
            3'd5:    t = f[14];
            3'd6:    t = |f[11:10];
            default: t = f[15];
        endcase
        return t;
    endfunction

endpackage

// File: rtl/core/ccff_unit.sv
// ----------------------------------------------------------------------------
// ccff_unit
// Shared datapath: one signed multiplier plus add/subtract logic, used for
// the fan-triangle cross products, the face area and the restoring divide.
// ----------------------------------------------------------------------------
module ccff_unit #(
    parameter int FRACTION_BITS = 16
) (
    input  logic                     i_clk,
    input  ccff_pkg::t_ctrl          i_ctrl,
    input  ccff_pkg::t_point         i_cur,
    input  logic [30:0]              i_ext_u,
    input  logic [30:0]              i_ext_v,
    output ccff_pkg::t_stat          o_stat,
    output logic [FRACTION_BITS-1:0] o_quot
);
    import ccff_pkg::*;

    t_point                   r_p0;
    t_point                   r_prev;
    logic signed [65:0]       r_pa;
    logic signed [65:0]       r_pb;
    logic signed [65:0]       r_cr;
    logic [67:0]              r_acc;
    logic [62:0]              r_den;
    logic [FRACTION_BITS-1:0] r_quot;

    logic signed [32:0] w_d1u, w_d1v, w_d2u, w_d2v;
    logic signed [32:0] w_ma, w_mb;
    logic signed [65:0] w_prod;
    logic [67:0]        w_cr_ext;
    logic [63:0]        w_shift;
    logic [63:0]        w_den64;
    logic [63:0]        w_diff;
    logic               w_ge;

    assign w_d1u = {r_prev.u[31], r_prev.u} - {r_p0.u[31], r_p0.u};
    assign w_d1v = {r_prev.v[31], r_prev.v} - {r_p0.v[31], r_p0.v};
    assign w_d2u = {i_cur.u[31], i_cur.u} - {r_p0.u[31], r_p0.u};
    assign w_d2v = {i_cur.v[31], i_cur.v} - {r_p0.v[31], r_p0.v};

    always_comb begin
        case (i_ctrl.op)
            OP_MUL_A: begin
                w_ma = w_d1u;
                w_mb = w_d2v;
            end
            OP_MUL_B: begin
                w_ma = w_d1v;
                w_mb = w_d2u;
            end
            default: begin
                w_ma = {2'b00, i_ext_u};
                w_mb = {2'b00, i_ext_v};
            end
        endcase
    end

    assign w_prod   = w_ma * w_mb;
    assign w_cr_ext = {{2{r_cr[65]}}, r_cr};
    assign w_shift  = {r_acc[62:0], 1'b0};
    assign w_den64  = {1'b0, r_den};
    assign w_ge     = w_shift >= w_den64;
    assign w_diff   = w_shift - w_den64;

    always_ff @(posedge i_clk) begin
        case (i_ctrl.op)
            OP_CLR:     r_acc <= '0;
            OP_LD_P0:   r_p0 <= i_cur;
            OP_LD_PREV: r_prev <= i_cur;
            OP_MUL_A:   r_pa <= w_prod;
            OP_MUL_B:   r_pb <= w_prod;
            OP_CROSS:   r_cr <= r_pa - r_pb;
            OP_ACC: begin
                r_acc  <= r_cr[65] ? r_acc - w_cr_ext : r_acc + w_cr_ext;
                r_prev <= i_cur;
            end
            OP_MUL_D:   r_den <= {w_prod[61:0], 1'b0};
            OP_DIV: begin
                r_acc  <= {4'b0000, (w_ge ? w_diff : w_shift)};
                r_quot <= {r_quot[FRACTION_BITS-2:0], w_ge};
            end
            default: ;
        endcase
    end

    assign o_stat.den_zero = r_den == '0;
    assign o_stat.acc_gt   = (|r_acc[67:63]) || (r_acc[62:0] > r_den);
    assign o_stat.acc_eq   = r_acc == {5'b00000, r_den};
    assign o_quot          = r_quot;

endmodule

// File: rtl/core/ccff_seq.sv
// ----------------------------------------------------------------------------
// ccff_seq
// Sequencer: shortcut classification, polygon scan with fan triangulation,
// area check and divide control, and the result register.
// ----------------------------------------------------------------------------
module ccff_seq #(
    parameter int FRACTION_BITS = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic [15:0]              i_flags,
    input  ccff_pkg::t_stat          i_stat,
    input  logic [FRACTION_BITS-1:0] i_quot,
    output ccff_pkg::t_ctrl          o_ctrl,
    output logic [2:0]               o_k,
    output logic                     o_busy,
    output logic                     o_valid,
    output ccff_pkg::t_res           o_res
);
    import ccff_pkg::*;

    localparam int CW = $clog2(FRACTION_BITS);
    localparam logic [FRACTION_BITS:0] FRAC_ONE     = {1'b1, {FRACTION_BITS{1'b0}}};
    localparam logic [FRACTION_BITS:0] FRAC_HALF_M1 = {2'b00, {(FRACTION_BITS-1){1'b1}}};

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_CLASS = 4'd1;
    localparam logic [3:0] S_SCAN  = 4'd2;
    localparam logic [3:0] S_MUL_A = 4'd3;
    localparam logic [3:0] S_MUL_B = 4'd4;
    localparam logic [3:0] S_CROSS = 4'd5;
    localparam logic [3:0] S_ACC   = 4'd6;
    localparam logic [3:0] S_FIN   = 4'd7;
    localparam logic [3:0] S_CHECK = 4'd8;
    localparam logic [3:0] S_DIV   = 4'd9;
    localparam logic [3:0] S_DONE  = 4'd10;

    logic [3:0]             r_state, n_state;
    logic [2:0]             r_k, n_k;
    logic [1:0]             r_n, n_n;
    logic [CW-1:0]          r_cnt, n_cnt;
    logic [FRACTION_BITS:0] r_frac, n_frac;
    logic                   r_err, n_err;
    logic                   r_div_path;

    logic [2:0] w_wet;
    logic [3:0] w_lsum;
    logic       w_take;

    assign w_wet  = 3'(i_flags[0]) + 3'(i_flags[1]) + 3'(i_flags[2]) + 3'(i_flags[3]);
    assign w_lsum = 4'(i_flags[5:4]) + 4'(i_flags[7:6]) + 4'(i_flags[9:8])
                  + 4'(i_flags[11:10]);
    assign w_take = cand_take(i_flags, r_k);

    always_comb begin
        n_state   = r_state;
        n_k       = r_k;
        n_n       = r_n;
        n_cnt     = r_cnt;
        n_frac    = r_frac;
        n_err     = r_err;
        o_ctrl.op = OP_NOP;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_state = S_CLASS;
                end
            end
            S_CLASS: begin
                o_ctrl.op = OP_CLR;
                n_k       = '0;
                n_n       = '0;
                n_err     = 1'b0;
                n_state   = S_DONE;
                if (w_wet == WET_ALL) begin
                    n_frac = FRAC_ONE;
                end else if (w_wet == WET_NONE) begin
                    n_frac = '0;
                end else if (w_lsum == LSUM_FULL || w_lsum == LSUM_THREE) begin
                    n_frac = FRAC_ONE;
                end else if (w_lsum == LSUM_HALF) begin
                    n_frac = FRAC_HALF_M1;
                end else begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (w_take && r_n == 2'd0) begin
                    o_ctrl.op = OP_LD_P0;
                end else if (w_take && r_n == 2'd1) begin
                    o_ctrl.op = OP_LD_PREV;
                end
                if (w_take && r_n != 2'd3) begin
                    n_n = r_n + 2'd1;
                end
                if (w_take && r_n[1]) begin
                    n_state = S_MUL_A;
                end else if (r_k == 3'd7) begin
                    n_state = S_FIN;
                end else begin
                    n_k = r_k + 3'd1;
                end
            end
            S_MUL_A: begin
                o_ctrl.op = OP_MUL_A;
                n_state   = S_MUL_B;
            end
            S_MUL_B: begin
                o_ctrl.op = OP_MUL_B;
                n_state   = S_CROSS;
            end
            S_CROSS: begin
                o_ctrl.op = OP_CROSS;
                n_state   = S_ACC;
            end
            S_ACC: begin
                o_ctrl.op = OP_ACC;
                if (r_k == 3'd7) begin
                    n_state = S_FIN;
                end else begin
                    n_k     = r_k + 3'd1;
                    n_state = S_SCAN;
                end
            end
            S_FIN: begin
                o_ctrl.op = OP_MUL_D;
                if (r_n != 2'd3) begin
                    n_frac  = '0;
                    n_err   = 1'b1;
                    n_state = S_DONE;
                end else begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                n_cnt   = '0;
                n_state = S_DONE;
                if (i_stat.den_zero) begin
                    n_frac = '0;
                    n_err  = 1'b1;
                end else if (i_stat.acc_gt) begin
                    n_frac = FRAC_ONE;
                    n_err  = 1'b1;
                end else if (i_stat.acc_eq) begin
                    n_frac = FRAC_ONE;
                end else begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                o_ctrl.op = OP_DIV;
                n_cnt     = r_cnt + 1'b1;
                if (r_cnt == CW'(FRACTION_BITS - 1)) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_k    <= n_k;
        r_n    <= n_n;
        r_cnt  <= n_cnt;
        r_frac <= n_frac;
        r_err  <= n_err;
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_CLASS) begin
            r_div_path <= 1'b0;
        end else if (r_state == S_DIV) begin
            r_div_path <= 1'b1;
        end
    end

    assign o_k     = r_k;
    assign o_busy  = r_state != S_IDLE;
    assign o_valid = r_state == S_DONE;
    assign o_res.wet_fraction   = r_div_path ? 17'({1'b0, i_quot}) : 17'(r_frac);
    assign o_res.geometry_error = r_err;

endmodule

// File: rtl/core/cut_cell_face_fluid_fraction.sv
// ----------------------------------------------------------------------------
// cut_cell_face_fluid_fraction
// Wetted fraction of one cut-cell face from corner flags, levels, cut points
// and cell extents.
//
//   channel   ports                        handshake
//   request   start, i_req (t_req)         taken when start && !busy
//   result    o_valid, o_res (t_res)       one-cycle strobe, no back-pressure
//
// Shortcut faces (all wet, none wet, level sum 8, 6 or 5) skip the polygon
// scan, the result strobe in the cycle before busy falls. A polygon face is
// scanned by fan triangles and then divided, the divide skipped when an
// extent is zero or the area reaches the face area: one shared 33x33
// multiplier runs two products per triangle plus the face area, and the
// divide retires one quotient bit per cycle. A face with fewer than three
// points ends after the scan with geometry_error set.
// Reset clears only the sequencer state register. Results cannot be stalled.
// ----------------------------------------------------------------------------
module cut_cell_face_fluid_fraction #(
    parameter int FRACTION_BITS = 16
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    input  ccff_pkg::t_req  i_req,
    output logic            busy,
    output logic            o_valid,
    output ccff_pkg::t_res  o_res
);
    import ccff_pkg::*;

    t_req                     r_req;
    t_ctrl                    w_ctrl;
    t_stat                    w_stat;
    t_point                   w_cur;
    logic [2:0]               w_k;
    logic [FRACTION_BITS-1:0] w_quot;

    always_ff @(posedge i_clk) begin
        if (start && !busy) begin
            r_req <= i_req;
        end
    end

    assign w_cur = cand_point(r_req, w_k);

    ccff_unit #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_unit (
        .i_clk   (i_clk),
        .i_ctrl  (w_ctrl),
        .i_cur   (w_cur),
        .i_ext_u (r_req.extent_u),
        .i_ext_v (r_req.extent_v),
        .o_stat  (w_stat),
        .o_quot  (w_quot)
    );

    ccff_seq #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_flags (r_req.face_flags),
        .i_stat  (w_stat),
        .i_quot  (w_quot),
        .o_ctrl  (w_ctrl),
        .o_k     (w_k),
        .o_busy  (busy),
        .o_valid (o_valid),
        .o_res   (o_res)
    );

endmodule
